FILE: rtl/rbpw_pkg.sv
`default_nettype none

package rbpw_pkg;

   // default panel geometry
   localparam int PANEL_WIDTH_DEF  = 128;
   localparam int PANEL_HEIGHT_DEF = 296;

   // port widths
   localparam int REQ_TDATA_W = 56;
   localparam int RSP_TDATA_W = 32;
   localparam int CSR_ADDR_W  = 1;
   localparam int CSR_DATA_W  = 2;

   // command codes
   localparam logic [1:0] CMD_DRAW = 2'd0;
   localparam logic [1:0] CMD_FILL = 2'd1;
   localparam logic [1:0] CMD_READ = 2'd2;
   localparam logic [1:0] CMD_NOP  = 2'd3;

   // register indexes
   localparam logic [CSR_ADDR_W-1:0] CSR_ROTATION  = 1'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_MONO_MODE = 1'd1;

   // gray codes, taken from color bits 15:6
   localparam logic [9:0] GRAY_DARK  = 10'd1;
   localparam logic [9:0] GRAY_LIGHT = 10'd2;
   localparam logic [9:0] GRAY_WHITE = 10'd3;

   // byte constants
   localparam logic [15:0] WHITE_COLOR = 16'hFFFF;
   localparam logic [7:0]  BYTE_ALL    = 8'hFF;
   localparam logic [7:0]  BYTE_NONE   = 8'h00;
   localparam logic [7:0]  MASK_MSB    = 8'h80;

endpackage

`default_nettype wire

FILE: rtl/rbpw_ram.sv
`default_nettype none

module rbpw_ram #(
   parameter int  WIDTH  = 8,
   parameter int  DEPTH  = 16,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: rtl/rotated_bitplane_pixel_writer_core.sv
`default_nettype none

// channel   dir  handshake              payload
// req       in   req_tvalid/req_tready  req_tdata: command, pixel_x, pixel_y, color, byte_index
// rsp       out  rsp_tvalid/rsp_tready  rsp_tdata: pixel_accepted, mono, first, second byte
// csr       in   csr_wen                csr_addr, csr_wdata (rotation, mono_mode)
//
// draw and read: S_CALC decodes and issues the memory read, then S_DATA writes back a draw
//   and loads the result; ready returns as the result loads, so one word is at work at a time
// fill: S_FILL writes one byte address per cycle over the buffer, then S_DONE loads the result
// reset: synchronous; a clearing pass over ROW_BYTES*PANEL_HEIGHT addresses (4736 by default)
//   writes white to the mono plane and zero to both gray planes, no word accepted meanwhile
// stalls: a result waits in the output register; a new word is still accepted, and its
//   write back holds until the output register is free

module rotated_bitplane_pixel_writer_core #(
   parameter int PANEL_WIDTH  = rbpw_pkg::PANEL_WIDTH_DEF,
   parameter int PANEL_HEIGHT = rbpw_pkg::PANEL_HEIGHT_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // command[1:0], pixel_x[12:2], pixel_y[23:13], color[39:24], byte_index[52:40]
   input  logic [rbpw_pkg::REQ_TDATA_W-1:0] req_tdata,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // pixel_accepted[0], mono_byte[8:1], first_plane_byte[16:9], second_plane_byte[24:17]
   output logic [rbpw_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input  logic                             csr_wen,
   input  logic [rbpw_pkg::CSR_ADDR_W-1:0]  csr_addr,
   input  logic [rbpw_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   import rbpw_pkg::*;

   localparam int ROW_BYTES = (PANEL_WIDTH + 7) / 8;
   localparam int BUF_BYTES = ROW_BYTES * PANEL_HEIGHT;
   localparam int AW        = $clog2(BUF_BYTES);

   localparam logic [10:0]   W_LIM    = 11'(PANEL_WIDTH);
   localparam logic [10:0]   H_LIM    = 11'(PANEL_HEIGHT);
   localparam logic [9:0]    W_MAX    = 10'(PANEL_WIDTH - 1);
   localparam logic [9:0]    H_MAX    = 10'(PANEL_HEIGHT - 1);
   localparam logic [AW-1:0] LAST_IDX = AW'(BUF_BYTES - 1);

   typedef enum logic [5:0] {
      S_CLEAR = 6'b000001,
      S_IDLE  = 6'b000010,
      S_CALC  = 6'b000100,
      S_DATA  = 6'b001000,
      S_FILL  = 6'b010000,
      S_DONE  = 6'b100000
   } state_type;

   state_type   state_ff, state_in;
   logic [AW-1:0] cnt_ff, cnt_in;
   logic [AW-1:0] addr_ff, addr_in;
   logic        acc_ff, acc_in;
   logic [1:0]  rotation_ff;
   logic        mono_mode_ff;

   // captured word
   logic [1:0]  cmd_ff;
   logic [10:0] x_ff;
   logic [10:0] y_ff;
   logic [15:0] color_ff;
   logic [12:0] bidx_ff;

   // output register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [RSP_TDATA_W-1:0] rsp_data_ff;

   // memory ports
   logic          rd_en;
   logic [AW-1:0] rd_addr;
   logic [AW-1:0] wr_addr;
   logic          mono_we, gray_we;
   logic [7:0]    mono_wdata;
   logic [15:0]   gray_wdata;
   logic [7:0]    mono_rdata;
   logic [15:0]   gray_rdata;

   logic       accept;
   logic       out_free;
   logic       load;
   logic [7:0] ld_mono, ld_first, ld_second;

   // draw address path
   logic [10:0] w_sel, h_sel;
   logic        in_bounds;
   logic [9:0]  px, py;
   logic [31:0] draw_idx;
   logic [31:0] read_idx;
   logic        read_ok;
   logic [7:0]  mask;
   logic [7:0]  first_new, second_new;
   logic [7:0]  fill_first, fill_second;

   assign accept     = req_tvalid && req_tready;
   assign req_tready = (state_ff == S_IDLE);
   assign out_free   = !rsp_valid_ff || rsp_tready;

   // rotated bounds and panel coordinate
   always_comb begin
      w_sel     = rotation_ff[0] ? H_LIM : W_LIM;
      h_sel     = rotation_ff[0] ? W_LIM : H_LIM;
      in_bounds = !x_ff[10] && ({1'b0, x_ff[9:0]} < w_sel)
               && !y_ff[10] && ({1'b0, y_ff[9:0]} < h_sel);
      case (rotation_ff)
         2'd1: begin
            px = W_MAX - y_ff[9:0];
            py = x_ff[9:0];
         end
         2'd2: begin
            px = W_MAX - x_ff[9:0];
            py = H_MAX - y_ff[9:0];
         end
         2'd3: begin
            px = y_ff[9:0];
            py = H_MAX - x_ff[9:0];
         end
         default: begin
            px = x_ff[9:0];
            py = y_ff[9:0];
         end
      endcase
      draw_idx = 32'(px >> 3) + 32'(py) * 32'(ROW_BYTES);
      read_idx = 32'(bidx_ff);
      read_ok  = read_idx < 32'(BUF_BYTES);
   end

   // bit mask, kept from the decode cycle
   logic [7:0] mask_ff;
   assign mask = MASK_MSB >> px[2:0];

   // gray plane update for a draw
   always_comb begin
      first_new  = gray_rdata[7:0];
      second_new = gray_rdata[15:8];
      case (color_ff[15:6])
         GRAY_DARK: begin
            first_new  = gray_rdata[7:0] & ~mask_ff;
            second_new = gray_rdata[15:8] | mask_ff;
         end
         GRAY_LIGHT: begin
            first_new  = gray_rdata[7:0] | mask_ff;
            second_new = gray_rdata[15:8] & ~mask_ff;
         end
         GRAY_WHITE: begin
            first_new  = gray_rdata[7:0] & ~mask_ff;
            second_new = gray_rdata[15:8] & ~mask_ff;
         end
         default: begin
            first_new  = gray_rdata[7:0] | mask_ff;
            second_new = gray_rdata[15:8] | mask_ff;
         end
      endcase
   end

   // gray fill bytes
   always_comb begin
      case (color_ff[15:6])
         GRAY_DARK: begin
            fill_first  = BYTE_NONE;
            fill_second = BYTE_ALL;
         end
         GRAY_LIGHT: begin
            fill_first  = BYTE_ALL;
            fill_second = BYTE_NONE;
         end
         GRAY_WHITE: begin
            fill_first  = BYTE_NONE;
            fill_second = BYTE_NONE;
         end
         default: begin
            fill_first  = BYTE_ALL;
            fill_second = BYTE_ALL;
         end
      endcase
   end

   // sequencer
   always_comb begin
      state_in   = state_ff;
      cnt_in     = cnt_ff;
      addr_in    = addr_ff;
      acc_in     = acc_ff;
      rd_en      = 1'b0;
      rd_addr    = draw_idx[AW-1:0];
      wr_addr    = cnt_ff;
      mono_we    = 1'b0;
      gray_we    = 1'b0;
      mono_wdata = BYTE_ALL;
      gray_wdata = {BYTE_NONE, BYTE_NONE};
      load       = 1'b0;
      ld_mono    = BYTE_NONE;
      ld_first   = BYTE_NONE;
      ld_second  = BYTE_NONE;
      unique case (state_ff)
         S_CLEAR: begin
            mono_we    = 1'b1;
            gray_we    = 1'b1;
            cnt_in     = cnt_ff + 1'b1;
            if (cnt_ff == LAST_IDX) begin
               cnt_in   = '0;
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               state_in = S_CALC;
            end
         end
         S_CALC: begin
            cnt_in = '0;
            acc_in = 1'b1;
            unique case (cmd_ff)
               CMD_DRAW: begin
                  if (in_bounds) begin
                     rd_en    = 1'b1;
                     addr_in  = draw_idx[AW-1:0];
                     state_in = S_DATA;
                  end else begin
                     acc_in   = 1'b0;
                     state_in = S_DONE;
                  end
               end
               CMD_FILL: begin
                  state_in = S_FILL;
               end
               CMD_READ: begin
                  if (read_ok) begin
                     rd_en    = 1'b1;
                     rd_addr  = read_idx[AW-1:0];
                     addr_in  = read_idx[AW-1:0];
                     state_in = S_DATA;
                  end else begin
                     state_in = S_DONE;
                  end
               end
               CMD_NOP: begin
                  state_in = S_DONE;
               end
            endcase
         end
         S_DATA: begin
            wr_addr    = addr_ff;
            mono_wdata = (color_ff != 16'd0) ? (mono_rdata | mask_ff)
                                             : (mono_rdata & ~mask_ff);
            gray_wdata = {second_new, first_new};
            if (out_free) begin
               load     = 1'b1;
               state_in = S_IDLE;
               if (cmd_ff == CMD_DRAW) begin
                  mono_we = mono_mode_ff;
                  gray_we = !mono_mode_ff;
               end else begin
                  ld_mono   = mono_rdata;
                  ld_first  = gray_rdata[7:0];
                  ld_second = gray_rdata[15:8];
               end
            end
         end
         S_FILL: begin
            mono_wdata = (color_ff == WHITE_COLOR) ? BYTE_ALL : BYTE_NONE;
            gray_wdata = {fill_second, fill_first};
            mono_we    = mono_mode_ff;
            gray_we    = !mono_mode_ff;
            cnt_in     = cnt_ff + 1'b1;
            if (cnt_ff == LAST_IDX) begin
               cnt_in   = '0;
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (out_free) begin
               load     = 1'b1;
               state_in = S_IDLE;
            end
         end
      endcase
   end

   assign rsp_valid_in = load ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         rotation_ff  <= 2'd0;
         mono_mode_ff <= 1'b1;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wen) begin
            unique case (csr_addr)
               CSR_ROTATION:  rotation_ff  <= csr_wdata[1:0];
               CSR_MONO_MODE: mono_mode_ff <= csr_wdata[0];
            endcase
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      addr_ff <= addr_in;
      acc_ff  <= acc_in;
      if (state_ff == S_CALC) begin
         mask_ff <= mask;
      end
      if (accept) begin
         cmd_ff   <= req_tdata[1:0];
         x_ff     <= req_tdata[12:2];
         y_ff     <= req_tdata[23:13];
         color_ff <= req_tdata[39:24];
         bidx_ff  <= req_tdata[52:40];
      end
      if (load) begin
         rsp_data_ff <= {7'd0, ld_second, ld_first, ld_mono, acc_ff};
      end
   end

   // mono plane
   rbpw_ram #(
      .WIDTH (8),
      .DEPTH (BUF_BYTES)
   ) u_mono_ram (
      .clock   (clock),
      .wr_en   (mono_we),
      .wr_addr (wr_addr),
      .wr_data (mono_wdata),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (mono_rdata)
   );

   // both gray planes, second plane in the upper byte
   rbpw_ram #(
      .WIDTH (16),
      .DEPTH (BUF_BYTES)
   ) u_gray_ram (
      .clock   (clock),
      .wr_en   (gray_we),
      .wr_addr (wr_addr),
      .wr_data (gray_wdata),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (gray_rdata)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

`default_nettype wire

FILE: rtl/rbpw_checker.sv
`default_nettype none

module rbpw_checker (
   input wire logic                             clock,
   input wire logic                             reset,
   input wire logic                             req_tvalid,
   input wire logic                             req_tready,
   input wire logic                             rsp_tvalid,
   input wire logic                             rsp_tready,
   input wire logic [rbpw_pkg::RSP_TDATA_W-1:0] rsp_tdata
);

   import rbpw_pkg::*;

   // no result straight out of reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result word right after reset");

   // a stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result word changed");

   // a rejected draw carries no plane bytes, padding stays zero
   a_reject_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[0] || (rsp_tdata[24:1] == 24'd0))
                     && (rsp_tdata[RSP_TDATA_W-1:25] == 7'd0))
      else $error("rejected draw with nonzero bytes");

   // one word in flight: ready drops after an accept
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("word accepted while another is at work");

endmodule

bind rotated_bitplane_pixel_writer_core rbpw_checker u_rbpw_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire
